// ===== src/brb_pkg.sv =====
package brb_pkg;

   // default geometry
   localparam int DEPTH_DEF    = 1024;
   localparam int MAX_READ_DEF = 64;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int BLEN_W  = 10;
   localparam int RLEN_W  = 7;
   localparam int FILL_W  = 10;

   // operation codes
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_EMPTY  = 2'd2
   } rsp_status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH_ADMIT,
      S_PUSH_WRITE,
      S_READ_SETUP,
      S_READ_RUN,
      S_MISC
   } ctrl_state_type;

   // request word as captured at accept
   typedef struct packed {
      logic [1:0]        operation;
      logic [BYTE_W-1:0] push_byte;
      logic              block_start;
      logic [BLEN_W-1:0] block_len;
      logic [RLEN_W-1:0] read_len;
      logic              commit;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic [1:0]        status;
      logic [FILL_W-1:0] fill_count;
      logic              last;
   } rsp_word_type;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;
      logic push_admit;
      logic push_write;
      logic read_setup;
      logic read_issue;
      logic emit_empty;
      logic misc_step;
   } ctrl_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic slot_free;
      logic read_none;
      logic read_final;
   } dp_stat_type;

endpackage

// ===== src/brb_req_if.sv =====
interface brb_req_if import brb_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [BYTE_W-1:0] push_byte;
   logic              block_start;
   logic [BLEN_W-1:0] block_len;
   logic [RLEN_W-1:0] read_len;
   logic              commit;

   modport source (
      output valid, operation, push_byte, block_start, block_len, read_len, commit,
      input  ready
   );
   modport sink (
      input  valid, operation, push_byte, block_start, block_len, read_len, commit,
      output ready
   );
endinterface

// ===== src/brb_rsp_if.sv =====
interface brb_rsp_if import brb_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_valid;
   logic [1:0]        status;
   logic [FILL_W-1:0] fill_count;
   logic              last;

   modport source (
      output valid, out_byte, byte_valid, status, fill_count, last,
      input  ready
   );
   modport sink (
      input  valid, out_byte, byte_valid, status, fill_count, last,
      output ready
   );
endinterface

// ===== src/brb_ctrl.sv =====
module brb_ctrl import brb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_op,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (op_type'(req_op))
                  OP_PUSH: state_in = S_PUSH_ADMIT;
                  OP_READ: state_in = S_READ_SETUP;
                  default: state_in = S_MISC;
               endcase
            end
         end
         S_PUSH_ADMIT: begin
            cmd.push_admit = 1'b1;
            state_in       = S_PUSH_WRITE;
         end
         S_PUSH_WRITE: begin
            if (stat.slot_free) begin
               cmd.push_write = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_READ_SETUP: begin
            cmd.read_setup = 1'b1;
            state_in       = S_READ_RUN;
         end
         S_READ_RUN: begin
            if (stat.slot_free) begin
               if (stat.read_none) begin
                  cmd.emit_empty = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.read_issue = 1'b1;
                  if (stat.read_final) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_MISC: begin
            if (stat.slot_free) begin
               cmd.misc_step = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/brb_datapath.sv =====
module brb_datapath import brb_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int MAX_READ = MAX_READ_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  logic         csr_write_en,
   input  logic         csr_write_data,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int FW    = (PTR_W > FILL_W) ? PTR_W : FILL_W;
   localparam int CW    = FW + 1;

   // pointer add modulo DEPTH, x never above DEPTH-1
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [CW-1:0]    x);
      logic [CW-1:0] sum;
      sum = CW'(p) + x;
      if (sum >= CW'(DEPTH)) begin
         sum = sum - CW'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // fill masked to the result field
   function automatic logic [FILL_W-1:0] fill_out(input logic [PTR_W-1:0] f);
      logic [FW-1:0] t;
      t = FW'(f);
      return t[FILL_W-1:0];
   endfunction

   // byte store
   logic [BYTE_W-1:0] mem [DEPTH];

   req_word_type      req_ff;
   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic              drop_ff, drop_in;
   logic              ow_ff;
   logic [PTR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [RLEN_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [PTR_W-1:0]  rd_fill_ff, rd_fill_in;
   logic              inflight_ff, inflight_in;
   logic              inflight_last_ff, inflight_last_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              mem_we;

   rsp_word_type      q_ff [2];
   logic              head_ff, head_in;
   logic [1:0]        qcnt_ff, qcnt_in;
   logic              pop, tail;
   logic [2:0]        occ;
   logic              enq_valid;
   rsp_word_type      enq_word;

   logic [PTR_W:0]    diff;
   logic [PTR_W-1:0]  fill, room;
   logic              full, too_long, short_room;
   logic [RLEN_W-1:0] cap, read_n;

   // current fill from the pointers
   always_comb begin
      diff = {1'b0, wp_ff} - {1'b0, rp_ff};
      if (diff[PTR_W]) begin
         fill = PTR_W'(diff + (PTR_W+1)'(DEPTH));
      end else begin
         fill = diff[PTR_W-1:0];
      end
      full       = (fill == PTR_W'(DEPTH - 1));
      room       = PTR_W'(DEPTH - 1) - fill;
      too_long   = CW'(req_ff.block_len) > CW'(DEPTH - 1);
      short_room = CW'(room) < CW'(req_ff.block_len);
      cap        = (req_ff.read_len > RLEN_W'(MAX_READ)) ? RLEN_W'(MAX_READ)
                                                         : req_ff.read_len;
      read_n     = (CW'(cap) > CW'(fill)) ? RLEN_W'(fill) : cap;
   end

   // output queue bookkeeping
   assign rsp_valid = (qcnt_ff != 2'd0);
   assign rsp_word  = q_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign tail      = head_ff ^ qcnt_ff[0];
   assign occ       = 3'(qcnt_ff) + 3'(inflight_ff);

   assign stat.slot_free  = (occ < 3'd2) || ((occ == 3'd2) && pop);
   assign stat.read_none  = (rd_cnt_ff == '0);
   assign stat.read_final = (rd_cnt_ff == RLEN_W'(1));

   // datapath next state
   always_comb begin
      wp_in            = wp_ff;
      rp_in            = rp_ff;
      drop_in          = drop_ff;
      mem_we           = 1'b0;
      rd_addr_in       = rd_addr_ff;
      rd_cnt_in        = rd_cnt_ff;
      rd_fill_in       = rd_fill_ff;
      inflight_in      = 1'b0;
      inflight_last_in = inflight_last_ff;
      enq_valid        = 1'b0;
      enq_word         = '0;
      enq_word.last    = 1'b1;

      // read byte returning from the store
      if (inflight_ff) begin
         enq_valid           = 1'b1;
         enq_word.out_byte   = rd_data_ff;
         enq_word.byte_valid = 1'b1;
         enq_word.status     = STAT_OK;
         enq_word.fill_count = fill_out(rd_fill_ff);
         enq_word.last       = inflight_last_ff;
      end

      // block admission on its first byte
      if (cmd.push_admit && req_ff.block_start) begin
         drop_in = too_long || (short_room && !ow_ff);
         if (!too_long && short_room && ow_ff) begin
            rp_in = ptr_add(rp_ff, CW'(req_ff.block_len));
         end
      end

      // store the byte or reject it
      if (cmd.push_write) begin
         enq_valid           = 1'b1;
         enq_word.fill_count = fill_out(fill);
         if (drop_ff || (full && !ow_ff)) begin
            enq_word.status = STAT_REJECT;
         end else begin
            enq_word.status = STAT_OK;
            mem_we          = 1'b1;
            wp_in           = ptr_add(wp_ff, CW'(1));
            if (full) begin
               rp_in = ptr_add(rp_ff, CW'(1));
            end else begin
               enq_word.fill_count = fill_out(fill + PTR_W'(1));
            end
         end
      end

      // read: size it, commit up front
      if (cmd.read_setup) begin
         rd_addr_in = rp_ff;
         rd_cnt_in  = read_n;
         rd_fill_in = fill;
         if (req_ff.commit) begin
            rp_in      = ptr_add(rp_ff, CW'(read_n));
            rd_fill_in = fill - PTR_W'(read_n);
         end
      end

      if (cmd.read_issue) begin
         rd_addr_in       = ptr_add(rd_addr_ff, CW'(1));
         rd_cnt_in        = rd_cnt_ff - RLEN_W'(1);
         inflight_in      = 1'b1;
         inflight_last_in = (rd_cnt_ff == RLEN_W'(1));
      end

      if (cmd.emit_empty) begin
         enq_valid           = 1'b1;
         enq_word.status     = STAT_EMPTY;
         enq_word.fill_count = fill_out(fill);
      end

      // clear, or the unused code
      if (cmd.misc_step) begin
         enq_valid           = 1'b1;
         enq_word.status     = STAT_OK;
         enq_word.fill_count = fill_out(fill);
         if (op_type'(req_ff.operation) == OP_CLEAR) begin
            wp_in               = '0;
            rp_in               = '0;
            drop_in             = 1'b0;
            enq_word.fill_count = '0;
         end
      end

      head_in = pop ? ~head_ff : head_ff;
      qcnt_in = qcnt_ff + 2'(enq_valid) - 2'(pop);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         drop_ff     <= 1'b0;
         ow_ff       <= 1'b0;
         rd_cnt_ff   <= '0;
         inflight_ff <= 1'b0;
         head_ff     <= 1'b0;
         qcnt_ff     <= '0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         drop_ff     <= drop_in;
         rd_cnt_ff   <= rd_cnt_in;
         inflight_ff <= inflight_in;
         head_ff     <= head_in;
         qcnt_ff     <= qcnt_in;
         if (csr_write_en) begin
            ow_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      rd_addr_ff       <= rd_addr_in;
      rd_fill_ff       <= rd_fill_in;
      inflight_last_ff <= inflight_last_in;
      if (enq_valid) begin
         q_ff[tail] <= enq_word;
      end
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= req_ff.push_byte;
      end
      if (cmd.read_issue) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

endmodule

// ===== src/byte_ring_buffer_fifo_top.sv =====
// Byte FIFO in a circular store of DEPTH bytes (DEPTH-1 usable). Words on req_ch push one byte,
// read up to MAX_READ bytes (commit consumes them, peek leaves them) or clear the buffer; every
// word yields result words on rsp_ch, one per byte read or one otherwise, with the fill count
// after the step and last set on the final one. Admission of a push block is decided on its
// first byte; csr_write_data sets overwrite mode (drop oldest bytes instead of rejecting), to
// be written only while the block is idle. A push passes accept, admission and store write, a
// clear or unused code accept and the misc step, a read accept, setup and one read of the single
// registered read port per byte; emitting steps wait for queue room. A two-word output queue lets
// the next request be taken while results still wait. The store holds no reset; it is usable
// right after reset with no clearing pass.
module byte_ring_buffer_fifo_top import brb_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int MAX_READ = MAX_READ_DEF
) (
   input  logic       clock,
   input  logic       reset,
   brb_req_if.sink    req_ch,
   brb_rsp_if.source  rsp_ch,
   input  logic       csr_write_en,
   input  logic       csr_write_data
);

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;
   req_word_type req_word;
   rsp_word_type rsp_word;
   logic         req_ready;
   logic         rsp_valid;

   assign req_word.operation   = req_ch.operation;
   assign req_word.push_byte   = req_ch.push_byte;
   assign req_word.block_start = req_ch.block_start;
   assign req_word.block_len   = req_ch.block_len;
   assign req_word.read_len    = req_ch.read_len;
   assign req_word.commit      = req_ch.commit;
   assign req_ch.ready         = req_ready;

   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.out_byte   = rsp_word.out_byte;
   assign rsp_ch.byte_valid = rsp_word.byte_valid;
   assign rsp_ch.status     = rsp_word.status;
   assign rsp_ch.fill_count = rsp_word.fill_count;
   assign rsp_ch.last       = rsp_word.last;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.operation),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   brb_datapath #(
      .DEPTH    (DEPTH),
      .MAX_READ (MAX_READ)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_word       (req_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (ctrl_cmd),
      .stat           (dp_stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_word       (rsp_word)
   );

   // an accepted word keeps the controller busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while previous word still in progress");

   // store reads only issue when the output queue can take the byte
   a_issue_has_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.read_issue |-> dp_stat.slot_free)
      else $error("store read issued without output queue space");

   // a data byte always reports ok status
   a_byte_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.byte_valid |-> rsp_ch.status == STAT_OK)
      else $error("read byte with non-ok status");

   // fill count never reaches the store depth (checked only for DEPTH up to 1024)
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (DEPTH > 1024) || (32'(rsp_ch.fill_count) < 32'(DEPTH)))
      else $error("fill count out of range");

endmodule
